// ===== design/smdr_pkg.sv =====
package smdr_pkg;

    localparam int W               = 32;
    localparam int NUM_W           = 2 * W - 1;
    localparam int QBITS_PER_STAGE = 2;
    localparam int DIV_STAGES      = W / QBITS_PER_STAGE;
    // input reg, multiply, round add, divider entry, divider stages, output reg
    localparam int LATENCY         = DIV_STAGES + 5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIVZERO  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic signed [W-1:0] value;
        logic signed [W-1:0] multiplier;
        logic signed [W-1:0] divisor;
    } t_in;

    typedef struct packed {
        logic signed [W-1:0] scaled;
        logic [1:0]          status;
    } t_out;

    typedef struct packed {
        logic neg;
        logic dz;
        logic ovf;
    } t_side;

    // rem: partial remainder, low: dividend bits not yet shifted in, quo: quotient so far
    typedef struct packed {
        logic [W-1:0] rem;
        logic [W-1:0] low;
        logic [W-1:0] quo;
    } t_divstate;

    function automatic logic [W-1:0] mag(input logic [W-1:0] x);
        logic [W-1:0] r;
        r = x[W-1] ? (~x + 1'b1) : x;
        return r;
    endfunction

    // QBITS_PER_STAGE steps of restoring division; rem stays below d when it enters below d
    function automatic t_divstate div_step(input t_divstate s, input logic [W-1:0] d);
        t_divstate  r;
        logic [W:0] trial;
        logic [W:0] diff;
        r = s;
        for (int k = 0; k < QBITS_PER_STAGE; k++) begin
            trial = {r.rem, r.low[W-1]};
            diff  = trial - {1'b0, d};
            r.low = {r.low[W-2:0], 1'b0};
            if (trial >= {1'b0, d}) begin
                r.rem = diff[W-1:0];
                r.quo = {r.quo[W-2:0], 1'b1};
            end else begin
                r.rem = trial[W-1:0];
                r.quo = {r.quo[W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

// ===== design/scaled_multiply_divide_round.sv =====
// Channel  Direction  Handshake           Payload
// command  in         start / busy        i_word (value, multiplier, divisor)
// result   out        o_valid strobe      o_word (scaled, status)
//
// One word per cycle while busy is low; results leave in command order.
// The restoring divider takes 2 quotient bits per stage, in 16 stages.
// Synchronous active-low reset clears all valid bits; busy is high during reset.
// The result strobe lasts one cycle and cannot be held off; no stalls anywhere.
module scaled_multiply_divide_round (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  smdr_pkg::t_in   i_word,
    output logic            o_valid,
    output smdr_pkg::t_out  o_word
);

    localparam int W = smdr_pkg::W;

    logic r_live;

    // stage 1: magnitudes and result sign
    logic            r_v1;
    logic [W-1:0]    r_am, r_bm, r_dm1;
    smdr_pkg::t_side r_side1;

    // stage 2: product
    logic            r_v2;
    logic [2*W-1:0]  r_pm;
    logic [W-1:0]    r_dm2;
    smdr_pkg::t_side r_side2;

    // stage 3: product plus half divisor
    logic                       r_v3;
    logic [smdr_pkg::NUM_W-1:0] r_num;
    logic [W-1:0]               r_dm3;
    smdr_pkg::t_side            r_side3;

    logic            d_valid;
    logic [W-1:0]    d_quo;
    smdr_pkg::t_side d_side;

    logic           r_valid_out;
    smdr_pkg::t_out r_out;
    smdr_pkg::t_out n_out;

    logic accept;
    assign accept = start && !busy;
    assign busy   = !r_live;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live      <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_valid_out <= 1'b0;
        end else begin
            r_live      <= 1'b1;
            r_v1        <= accept;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_valid_out <= d_valid;
        end
        r_am        <= smdr_pkg::mag(i_word.value);
        r_bm        <= smdr_pkg::mag(i_word.multiplier);
        r_dm1       <= smdr_pkg::mag(i_word.divisor);
        r_side1.neg <= (i_word.value[W-1] ^ i_word.multiplier[W-1]) ^ i_word.divisor[W-1];
        r_side1.dz  <= (i_word.divisor == '0);
        r_side1.ovf <= 1'b0;

        r_pm    <= {{W{1'b0}}, r_am} * {{W{1'b0}}, r_bm};
        r_dm2   <= r_dm1;
        r_side2 <= r_side1;

        // round half away from zero on magnitudes
        r_num   <= r_pm[smdr_pkg::NUM_W-1:0]
                   + {{(smdr_pkg::NUM_W-W+1){1'b0}}, r_dm2[W-1:1]};
        r_dm3   <= r_dm2;
        r_side3 <= r_side2;

        r_out   <= n_out;
    end

    smdr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v3),
        .i_num   (r_num),
        .i_den   (r_dm3),
        .i_side  (r_side3),
        .o_valid (d_valid),
        .o_quo   (d_quo),
        .o_side  (d_side)
    );

    // range check: negative side reaches 2^31, positive side 2^31 - 1
    always_comb begin
        n_out.scaled = '1;
        n_out.status = smdr_pkg::ST_OK;
        if (d_side.dz) begin
            n_out.status = smdr_pkg::ST_DIVZERO;
        end else if (d_side.ovf
                     || (d_side.neg && d_quo > {1'b1, {(W-1){1'b0}}})
                     || (!d_side.neg && d_quo[W-1])) begin
            n_out.status = smdr_pkg::ST_OVERFLOW;
        end else if (d_side.neg) begin
            n_out.scaled = ~d_quo + 1'b1;
        end else begin
            n_out.scaled = d_quo;
        end
    end

    assign o_valid = r_valid_out;
    assign o_word  = r_out;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##(smdr_pkg::LATENCY) o_valid)
        else $error("word dropped in pipeline");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, smdr_pkg::LATENCY))
        else $error("result without a command");

    a_divzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_word.divisor == '0)
        |-> ##(smdr_pkg::LATENCY) (o_word.status == smdr_pkg::ST_DIVZERO))
        else $error("zero divisor not flagged");

    a_err_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_word.status != smdr_pkg::ST_OK) |-> (o_word.scaled == '1))
        else $error("error result not all ones");

endmodule

// ===== design/smdr_div.sv =====
module smdr_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [smdr_pkg::NUM_W-1:0]    i_num,
    input  logic [smdr_pkg::W-1:0]        i_den,
    input  smdr_pkg::t_side               i_side,
    output logic                          o_valid,
    output logic [smdr_pkg::W-1:0]        o_quo,
    output smdr_pkg::t_side               o_side
);

    localparam int N = smdr_pkg::DIV_STAGES;
    localparam int W = smdr_pkg::W;

    logic                r_valid [0:N];
    smdr_pkg::t_divstate r_st    [0:N];
    logic [W-1:0]        r_den   [0:N];
    smdr_pkg::t_side     r_side  [0:N];

    smdr_pkg::t_side n_side0;

    // quotient fits 32 bits only when the top dividend bits are below the divisor
    always_comb begin
        n_side0     = i_side;
        n_side0.ovf = ({1'b0, i_num[smdr_pkg::NUM_W-1:W]} >= i_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= N; s++) begin
                r_valid[s] <= 1'b0;
            end
        end else begin
            r_valid[0] <= i_valid;
            for (int s = 0; s < N; s++) begin
                r_valid[s+1] <= r_valid[s];
            end
        end
        r_st[0].rem <= {1'b0, i_num[smdr_pkg::NUM_W-1:W]};
        r_st[0].low <= i_num[W-1:0];
        r_st[0].quo <= '0;
        r_den[0]    <= i_den;
        r_side[0]   <= n_side0;
        for (int s = 0; s < N; s++) begin
            r_st[s+1]   <= smdr_pkg::div_step(r_st[s], r_den[s]);
            r_den[s+1]  <= r_den[s];
            r_side[s+1] <= r_side[s];
        end
    end

    assign o_valid = r_valid[N];
    assign o_quo   = r_st[N].quo;
    assign o_side  = r_side[N];

    // remainder must be below the divisor at the last stage for a word with a nonzero divisor that did not overflow
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid[N] && !r_side[N].dz && !r_side[N].ovf) |-> (r_st[N].rem < r_den[N]))
        else $error("divider remainder not below divisor");

    a_valid_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ##(N+1) o_valid)
        else $error("divider lost a word");

endmodule

// ===== bench/tb_scaled_multiply_divide_round.sv =====
`timescale 1ns / 100ps

class scale_scoreboard;
    smdr_pkg::t_out expected_results[$];
    int   errors = 0;

    // rounded scaled quotient for one command word, ties away from zero
    function smdr_pkg::t_out round_scaled(smdr_pkg::t_in w);
        smdr_pkg::t_out r;
        logic [31:0] am, bm, dm;
        logic [63:0] q;
        logic        neg;
        r.scaled = '1;
        if (w.divisor == 0) begin
            r.status = smdr_pkg::ST_DIVZERO;
            return r;
        end
        am  = w.value[31]      ? ~w.value + 32'd1      : w.value;
        bm  = w.multiplier[31] ? ~w.multiplier + 32'd1 : w.multiplier;
        dm  = w.divisor[31]    ? ~w.divisor + 32'd1    : w.divisor;
        neg = w.value[31] ^ w.multiplier[31] ^ w.divisor[31];
        q   = ({32'd0, am} * {32'd0, bm} + {33'd0, dm[31:1]}) / {32'd0, dm};
        if (q > (neg ? 64'h8000_0000 : 64'h7FFF_FFFF)) begin
            r.status = smdr_pkg::ST_OVERFLOW;
        end else begin
            r.status = smdr_pkg::ST_OK;
            r.scaled = neg ? -q[31:0] : q[31:0];
        end
        return r;
    endfunction

    function void note_command(smdr_pkg::t_in w);
        expected_results.push_back(round_scaled(w));
    endfunction

    function void check_result(smdr_pkg::t_out got);
        smdr_pkg::t_out want;
        if (expected_results.size() == 0) begin
            $display("%0t unexpected result: scaled %0d status %0d",
                     $time, got.scaled, got.status);
            errors++;
            return;
        end
        want = expected_results.pop_front();
        if (got.scaled !== want.scaled) begin
            $display("%0t scaled mismatch: expected %0d, actual %0d",
                     $time, want.scaled, got.scaled);
            errors++;
        end
        if (got.status !== want.status) begin
            $display("%0t status mismatch: expected %0d, actual %0d",
                     $time, want.status, got.status);
            errors++;
        end
    endfunction

    function int pending();
        return expected_results.size();
    endfunction
endclass

module tb_scaled_multiply_divide_round;

    localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
    localparam int NUM_RANDOM  = 1925;
    localparam int CALM_TAIL   = 300;
    localparam int CYCLE_LIMIT = 400000;

    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start   = 1'b0;
    logic           busy;
    smdr_pkg::t_in  i_word  = '0;
    logic           o_valid;
    smdr_pkg::t_out o_word;

    int unsigned     cycles = 0;
    scale_scoreboard sb;

    scaled_multiply_divide_round uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_word  (i_word),
        .o_valid (o_valid),
        .o_word  (o_word)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // a command word is taken at an edge with start high and busy low
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) sb.note_command(i_word);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_result(o_word);
    end

    function automatic smdr_pkg::t_in mk(logic signed [31:0] v, logic signed [31:0] m,
                                         logic signed [31:0] d);
        smdr_pkg::t_in w;
        w.value      = v;
        w.multiplier = m;
        w.divisor    = d;
        return w;
    endfunction

    function automatic logic signed [31:0] rand_sign(logic signed [31:0] x);
        return $urandom_range(0, 1) ? -x : x;
    endfunction

    function automatic smdr_pkg::t_in random_command();
        smdr_pkg::t_in      w;
        logic signed [31:0] m;
        int unsigned        pick;
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            w = mk($urandom, $urandom, $urandom);
        end else if (pick < 40) begin
            w = mk(rand_sign($urandom_range(0, 4096)), rand_sign($urandom_range(0, 4096)),
                   rand_sign($urandom_range(1, 256)));
        end else if (pick < 60) begin
            // v * m / 2m is an exact half whenever v is odd
            m = rand_sign($urandom_range(1, 32'h3FFF_FFFF));
            w = mk($urandom | 32'd1, m, rand_sign(2 * m));
            if ($urandom_range(0, 1)) w = mk(w.multiplier, w.value, w.divisor);
        end else if (pick < 80) begin
            // quotient lands near the value itself, so near the range edges too
            w.divisor    = rand_sign($urandom_range(1, 32'h7FFF_FFFF));
            w.multiplier = w.divisor + $signed($urandom_range(0, 4)) - 2;
            w.value      = $urandom;
        end else if (pick < 88) begin
            w = mk($urandom, $urandom, 0);
        end else begin
            w = mk(rand_sign($urandom_range(0, 32'h0000_FFFF)), $urandom,
                   rand_sign($urandom_range(32'h0001_0000, 32'h7FFF_FFFF)));
        end
        return w;
    endfunction

    task automatic send_word(smdr_pkg::t_in w);
        i_word <= w;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic idle_gap(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    initial begin
        smdr_pkg::t_in directed[$];
        bit  gaps_on;
        int  k;
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed.push_back(mk(INT_MAX, INT_MAX, 1));
        directed.push_back(mk(INT_MIN, INT_MIN, 1));
        directed.push_back(mk(INT_MIN, 1, -1));
        directed.push_back(mk(INT_MIN, 1, 1));
        directed.push_back(mk(INT_MIN, -1, 1));
        directed.push_back(mk(INT_MAX, -1, 1));
        directed.push_back(mk(INT_MIN, INT_MIN, INT_MIN));
        directed.push_back(mk(INT_MAX, INT_MAX, INT_MAX));
        directed.push_back(mk(INT_MAX, INT_MAX, INT_MIN));
        directed.push_back(mk(123, 456, 0));
        directed.push_back(mk(0, 0, 0));
        directed.push_back(mk(INT_MIN, INT_MIN, 0));
        directed.push_back(mk(0, 77, -5));
        directed.push_back(mk(INT_MIN, 0, INT_MIN));
        directed.push_back(mk(5, 1, 2));
        directed.push_back(mk(-5, 1, 2));
        directed.push_back(mk(5, 1, -2));
        directed.push_back(mk(-5, -1, -2));
        directed.push_back(mk(7, 1, -2));
        directed.push_back(mk(1, 1, -2));
        directed.push_back(mk(32'sh4000_0000, 1, INT_MIN));
        directed.push_back(mk(4, 1, 3));
        directed.push_back(mk(5, 1, 3));
        directed.push_back(mk(32'sh4000_0000, 2, 1));
        directed.push_back(mk(32'sh4000_0000, -2, 1));

        foreach (directed[i]) begin
            send_word(directed[i]);
            if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 15));
        end

        gaps_on = 1'b1;
        for (k = 0; k < NUM_RANDOM; k++) begin
            if (k % 64 == 0) gaps_on = $urandom_range(0, 2) != 0;
            send_word(random_command());
            if (gaps_on && k < NUM_RANDOM - CALM_TAIL && $urandom_range(0, 5) == 0)
                idle_gap($urandom_range(1, 15));
        end
        start <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (smdr_pkg::LATENCY + 5) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/smdr_pkg.sv
design/smdr_div.sv
design/scaled_multiply_divide_round.sv
bench/tb_scaled_multiply_divide_round.sv
